/* rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rtod_pkg.sv */
`default_nettype none
package rtod_pkg;

    localparam int unsigned TempW   = 7;
    localparam int unsigned TrimW   = 6;
    localparam int unsigned CodeW   = 7;
    localparam int unsigned StageW  = 4;
    localparam int unsigned IdxW    = 5;
    localparam int unsigned CurveW  = 8;
    localparam int unsigned SumW    = 10;
    localparam int unsigned ProdW   = 29;
    localparam int unsigned ScaledW = 9;

    localparam logic [TempW-1:0]  CenterC    = 7'd25;
    localparam logic [IdxW-1:0]   MaxIndex   = 5'd27;
    localparam logic [StageW-1:0] StageLast  = 4'd9;
    localparam logic [7:0]        CodeBase   = 8'h80;
    localparam logic [18:0]       ScaleRecip = 19'd343800;
    localparam logic [7:0]        TenRecip   = 8'd205;
    localparam logic [7:0]        SatMax     = 8'd255;

    localparam logic [2:0] AddrTrim = 3'd0;

    function automatic logic [CurveW-1:0] curve_lookup(input logic [IdxW-1:0] idx);
        logic [CurveW-1:0] v;
        case (idx)
            5'd0:  v = 8'd0;
            5'd1:  v = 8'd0;
            5'd2:  v = 8'd1;
            5'd3:  v = 8'd3;
            5'd4:  v = 8'd6;
            5'd5:  v = 8'd9;
            5'd6:  v = 8'd13;
            5'd7:  v = 8'd17;
            5'd8:  v = 8'd22;
            5'd9:  v = 8'd28;
            5'd10: v = 8'd35;
            5'd11: v = 8'd42;
            5'd12: v = 8'd50;
            5'd13: v = 8'd59;
            5'd14: v = 8'd69;
            5'd15: v = 8'd79;
            5'd16: v = 8'd90;
            5'd17: v = 8'd101;
            5'd18: v = 8'd113;
            5'd19: v = 8'd126;
            5'd20: v = 8'd140;
            5'd21: v = 8'd154;
            5'd22: v = 8'd169;
            5'd23: v = 8'd185;
            5'd24: v = 8'd202;
            5'd25: v = 8'd219;
            5'd26: v = 8'd237;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/rtc_temperature_offset_dither.sv */
// Temperature-driven digital offset code for a clock chip, with a ten-step dither.
// Requests arrive on the slave stream: tdata carries the temperature in whole
// degrees Celsius, tuser carries the reinit flag that clears the dither stage
// before the request is processed. Each request yields exactly one result on the
// master stream: the offset code and the dither stage used for it.
// The trim register sits at APB address 0; the user must write it only while
// idle, as the block does not enforce this. The input register loads at the
// accepting edge and the result register when the request advances, with the
// table lookup, the constant scaling and the digit split in between. The sustained
// rate is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// fills; the slave side then stalls too, and nothing is lost or repeated.
// Reset clears both valid flags, the dither stage and the trim register.
`default_nettype none
`include "assert_macros.svh"
module rtc_temperature_offset_dither
    import rtod_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [6:0] temperature, [7] zero
    input  wire logic        i_s_axis_tuser,   // [0] reinit
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [6:0] offset_code, [10:7] dither_stage
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    logic               r_in_valid;
    logic [TempW-1:0]   r_temp;
    logic               r_reinit;
    logic               r_out_valid;
    logic [CodeW-1:0]   r_code;
    logic [StageW-1:0]  r_used;
    logic [StageW-1:0]  r_stage;
    logic [TrimW-1:0]   r_trim;

    logic               advance;
    logic               in_fire;
    logic [StageW-1:0]  used;
    logic [StageW-1:0]  n_stage;
    logic [TempW-1:0]   dist_raw;
    logic [IdxW-1:0]    tab_idx;
    logic [SumW-1:0]    sum;
    logic [ProdW-1:0]   prod;
    logic [ScaledW-1:0] scaled_raw;
    logic [7:0]         scaled;
    logic [15:0]        tens_prod;
    logic [4:0]         tens;
    logic [3:0]         units;
    logic [4:0]         weight;
    logic [CodeW-1:0]   n_code;
    logic [7:0]         code_full;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        used     = r_reinit ? '0 : r_stage;
        n_stage  = (used == StageLast) ? '0 : used + 4'd1;
        dist_raw = (r_temp < CenterC) ? (CenterC - r_temp) : (r_temp - CenterC);
        tab_idx  = (dist_raw > TempW'(MaxIndex)) ? MaxIndex : dist_raw[IdxW-1:0];
        sum      = SumW'(curve_lookup(tab_idx)) + SumW'(r_trim) * SumW'(10);
        prod     = ProdW'(sum) * ProdW'(ScaleRecip);
        scaled_raw = prod[ProdW-1:ProdW-ScaledW];
        scaled   = scaled_raw[8] ? SatMax : scaled_raw[7:0];
        tens_prod = 16'(scaled) * 16'(TenRecip);
        tens     = tens_prod[15:11];
        units    = 4'(scaled - 8'(tens) * 8'd10);
        weight   = tens + ((used <= units) ? 5'd1 : 5'd0);
        code_full = CodeBase - 8'(weight);
        n_code   = (weight != '0) ? code_full[CodeW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stage     <= '0;
            r_trim      <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_stage     <= n_stage;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_psel && i_penable && i_pwrite && o_pready && i_paddr == AddrTrim) begin
                r_trim <= i_pwdata[TrimW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_temp   <= i_s_axis_tdata[TempW-1:0];
            r_reinit <= i_s_axis_tuser;
        end
        if (advance) begin
            r_code <= n_code;
            r_used <= used;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_used, r_code};
    assign o_pready        = 1'b1;
    assign o_prdata        = (i_paddr == AddrTrim) ? 32'(r_trim) : '0;

    `ASSERT_ALWAYS(a_stage_range, i_clk, i_rst_n, r_stage <= StageLast, "dither stage out of range")
    `ASSERT_ALWAYS(a_code_range, i_clk, i_rst_n,
        !r_out_valid || r_code == '0 || r_code >= 7'd102, "offset code out of range")
    `ASSERT_NEXT(a_stage_step, i_clk, i_rst_n, advance && !r_reinit,
        r_stage == (($past(r_stage) == StageLast) ? 4'd0 : $past(r_stage) + 4'd1),
        "dither stage did not advance")
    `ASSERT_NEXT(a_result_used, i_clk, i_rst_n, advance && r_reinit,
        r_used == 4'd0 && r_stage == 4'd1, "reinit did not clear the dither stage")

endmodule
`default_nettype wire

/* sim/tb_rtc_temperature_offset_dither.sv */
`default_nettype none
module tb_rtc_temperature_offset_dither;
    timeunit 1ns;
    timeprecision 1ps;
    import rtod_pkg::*;

    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned Phases    = 8;
    localparam int unsigned PhaseLen  = 213;

    typedef struct packed {
        logic [CodeW-1:0]  code;
        logic [StageW-1:0] stage;
    } t_offset_res;

    typedef struct packed {
        logic [TrimW-1:0]  trim;
        logic [TempW-1:0]  temp;
        logic              reinit;
        logic              pinned;
        logic [CodeW-1:0]  code;
        logic [StageW-1:0] stage;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        pin_on = 1'b0;
    logic [CodeW-1:0]  pin_code = '0;
    logic [StageW-1:0] pin_stage = '0;

    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [15:0]  o_m_axis_tdata;
    wire [31:0]  o_prdata;
    wire         o_pready;

    int unsigned curve_tab [28] = '{
        0, 0, 1, 3, 6, 9, 13, 17, 22, 28,
        35, 42, 50, 59, 69, 79, 90, 101, 113, 126,
        140, 154, 169, 185, 202, 219, 237, 255
    };

    logic [TrimW-1:0]  trim_cfg = '0;
    logic [StageW-1:0] dither_pos = '0;
    t_offset_res       offset_q[$];
    int unsigned       mismatches = 0;
    int unsigned       idle_cycles = 0;
    logic              s_calm = 1'b0;
    logic              m_calm = 1'b0;

    rtc_temperature_offset_dither dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),    // [6:0] temperature, [7] zero
        .i_s_axis_tuser  (s_user),    // [0] reinit
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [6:0] offset_code, [10:7] dither_stage
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_offset_res offset_predict(input logic [TempW-1:0] temp,
                                                   input logic reinit);
        t_offset_res r;
        int unsigned tab_idx;
        int unsigned scaled;
        int unsigned weight;
        int unsigned used;
        if (reinit) begin
            dither_pos = '0;
        end
        used = dither_pos;
        tab_idx = (temp < 25) ? 25 - temp : temp - 25;
        if (tab_idx > 27) begin
            tab_idx = 27;
        end
        scaled = ((curve_tab[tab_idx] + trim_cfg * 10) * 100) / 305;
        if (scaled > 255) begin
            scaled = 255;
        end
        weight = scaled / 10;
        if (used <= scaled % 10) begin
            weight = weight + 1;
        end
        if (weight != 0) begin
            weight = 128 - weight;
        end
        r.code = weight[CodeW-1:0];
        r.stage = used[StageW-1:0];
        dither_pos = (dither_pos == StageLast) ? '0 : dither_pos + 1'b1;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // Each accepted request is predicted at the edge that accepts it.
    always @(posedge i_clk) begin
        t_offset_res r;
        if (i_rst_n && s_valid && o_s_axis_tready) begin
            r = offset_predict(s_data[TempW-1:0], s_user);
            if (pin_on) begin
                r.code = pin_code;
                r.stage = pin_stage;
            end
            offset_q.push_back(r);
        end
    end

    always @(posedge i_clk) begin
        t_offset_res r;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (offset_q.size() == 0) begin
                note_mismatch("unrequested result, code", 0, o_m_axis_tdata[6:0]);
            end else begin
                r = offset_q.pop_front();
                if (o_m_axis_tdata[6:0] !== r.code) begin
                    note_mismatch("offset_code", r.code, o_m_axis_tdata[6:0]);
                end
                if (o_m_axis_tdata[10:7] !== r.stage) begin
                    note_mismatch("dither_stage", r.stage, o_m_axis_tdata[10:7]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IdleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = m_calm ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    task automatic send_request(input logic [TempW-1:0] temp, input logic reinit,
                                input logic pinned, input logic [CodeW-1:0] code,
                                input logic [StageW-1:0] stage);
        int unsigned n;
        n = s_calm ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {1'b0, temp};
        s_user <= reinit;
        pin_on <= pinned;
        pin_code <= code;
        pin_stage <= stage;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (offset_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic trim_write(input logic [TrimW-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrTrim;
        pwdata <= {{(32-TrimW){1'b0}}, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        trim_cfg = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (o_prdata !== {{(32-TrimW){1'b0}}, v}) begin
            note_mismatch("trim readback", v, o_prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_stim_row rows [17];
        logic [TrimW-1:0] trim_now;
        logic [TempW-1:0] temp;
        logic [TrimW-1:0] trim_plan [Phases];
        rows = '{
            '{6'd0,  7'd25,  1'b0, 1'b1, 7'd127, 4'd0},
            '{6'd0,  7'd25,  1'b0, 1'b1, 7'd0,   4'd1},
            '{6'd0,  7'd0,   1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd0,  7'd127, 1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd0,  7'd52,  1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd0,  7'd53,  1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd0,  7'd24,  1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd0,  7'd26,  1'b1, 1'b1, 7'd127, 4'd0},
            '{6'd52, 7'd0,   1'b1, 1'b0, 7'd0,   4'd0},
            '{6'd52, 7'd127, 1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd52, 7'd85,  1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd52, 7'd42,  1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd63, 7'd127, 1'b1, 1'b1, 7'd102, 4'd0},
            '{6'd63, 7'd0,   1'b0, 1'b1, 7'd102, 4'd1},
            '{6'd63, 7'd25,  1'b0, 1'b0, 7'd0,   4'd0},
            '{6'd1,  7'd25,  1'b1, 1'b1, 7'd127, 4'd0},
            '{6'd1,  7'd106, 1'b0, 1'b0, 7'd0,   4'd0}
        };
        trim_plan[0] = 6'd0;
        trim_plan[1] = 6'd63;
        trim_plan[2] = 6'd52;
        for (int p = 3; p < Phases; p++) begin
            trim_plan[p] = 6'($urandom_range(0, 63));
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The trim register comes out of reset as zero.
        trim_now = '0;
        foreach (rows[i]) begin
            if (rows[i].trim != trim_now) begin
                settle();
                trim_write(rows[i].trim);
                trim_now = rows[i].trim;
            end
            send_request(rows[i].temp, rows[i].reinit, rows[i].pinned,
                         rows[i].code, rows[i].stage);
        end

        for (int p = 0; p < Phases; p++) begin
            settle();
            trim_write(trim_plan[p]);
            s_calm = ($urandom_range(0, 3) == 0);
            m_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PhaseLen; k++) begin
                if ($urandom_range(0, 9) < 6) begin
                    temp = 7'($urandom_range(0, 52));
                end else begin
                    temp = 7'($urandom_range(0, 127));
                end
                send_request(temp, ($urandom_range(0, 11) == 0), 1'b0, '0, '0);
            end
        end

        settle();
        mismatches += offset_q.size();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
